>>> sv/ils_pkg.sv
package ils_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned OpBits    = 3;
  localparam int unsigned PosBits   = 7;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned CountBits = 7;

endpackage

>>> sv/indexed_list_store.sv
// Ordered list of up to DEPTH words kept in a single-port-read, single-port-write
// memory, with an element count. A command is transferred when start is high
// and busy is low; every command gives exactly one result, shown for one cycle
// with result_valid_o high, and the receiver cannot stall it. Append, clear,
// unused opcodes and every refused command give their result in the cycle after
// the transfer and leave busy low, so a new command may follow at once. Get,
// insert and remove hold busy high while they run: get reads one entry, and
// insert and remove each move the later entries one place through the memory,
// one entry per cycle, behind the memory's registered read; an insert at the
// end of the list moves no entries.
// A negative index for remove and get counts back from the end of the list.
module indexed_list_store #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ils_pkg::OpBits-1:0]           opcode_i,
  input  logic signed [ils_pkg::PosBits-1:0]   position_i,
  input  logic [ils_pkg::ValueBits-1:0]        item_value_i,
  output logic                                 result_valid_o,
  output logic [ils_pkg::ValueBits-1:0]        read_value_o,
  output logic [1:0]                           status_o,
  output logic [ils_pkg::CountBits-1:0]        held_count_o
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IW    =
      ((CNT_W > ils_pkg::PosBits) ? CNT_W : ils_pkg::PosBits) + 2;
  localparam int unsigned RB    =
      (WORD_BITS > ils_pkg::ValueBits) ? WORD_BITS : ils_pkg::ValueBits;
  localparam int unsigned HB    =
      (CNT_W > ils_pkg::CountBits) ? CNT_W : ils_pkg::CountBits;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic                 state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 issue_q, issue_d;
  logic                 rv_q, rv_d;
  logic                 res_valid_q, res_valid_d;

  ils_pkg::opcode_e     op_q, op_d;
  logic [AW-1:0]        slot_q, slot_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        last_q, last_d;
  logic [AW-1:0]        raddr_q;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [WORD_BITS-1:0] rdata_q;
  logic [WORD_BITS-1:0] res_word_q, res_word_d;
  logic [1:0]           res_status_q, res_status_d;

  logic                 accept;
  logic                 full;
  logic                 finish;
  logic                 capture;
  logic                 shift_wr;
  logic                 re;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] word_in;
  logic [AW-1:0]        cnt_m1;

  logic signed [IW-1:0] pos_s;
  logic signed [IW-1:0] cnt_s;
  logic signed [IW-1:0] idx_s;
  logic                 ins_ok;
  logic                 rg_ok;

  logic [RB-1:0]        res_wide;
  logic [HB-1:0]        cnt_wide;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign full    = (count_q >= CNT_W'(DEPTH));
  assign word_in = WORD_BITS'(item_value_i);
  assign cnt_m1  = AW'(count_q - CNT_W'(1));

  // Index checks are done in a signed width that holds both the position and
  // the count, so a position from the end can be resolved with one add.
  assign pos_s  = {{(IW - ils_pkg::PosBits){position_i[ils_pkg::PosBits-1]}}, position_i};
  assign cnt_s  = signed'(IW'(count_q));
  assign idx_s  = pos_s[IW-1] ? (pos_s + cnt_s) : pos_s;
  assign ins_ok = !pos_s[IW-1] && (pos_s <= cnt_s);
  assign rg_ok  = !idx_s[IW-1] && (idx_s < cnt_s);

  assign finish   = (state_q == S_RUN) && !issue_q && !rv_q;
  assign capture  = rv_q && (op_q != ils_pkg::OP_INSERT) && (raddr_q == slot_q);
  assign shift_wr = rv_q && ((op_q == ils_pkg::OP_INSERT) ||
                             ((op_q == ils_pkg::OP_REMOVE) && (raddr_q != slot_q)));
  assign re       = (state_q == S_RUN) && issue_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    ptr_d        = ptr_q;
    last_d       = last_q;
    op_d         = op_q;
    slot_d       = slot_q;
    word_d       = word_q;
    res_valid_d  = 1'b0;
    res_word_d   = res_word_q;
    res_status_d = res_status_q;
    we           = 1'b0;
    waddr        = slot_q;
    wdata        = word_q;

    if (accept) begin
      op_d         = ils_pkg::opcode_e'(opcode_i);
      word_d       = word_in;
      res_word_d   = '0;
      res_status_d = ils_pkg::ST_DONE;
      case (opcode_i)
        ils_pkg::OP_APPEND: begin
          res_valid_d = 1'b1;
          if (full) begin
            res_status_d = ils_pkg::ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = count_q[AW-1:0];
            wdata   = word_in;
            count_d = count_q + CNT_W'(1);
          end
        end
        ils_pkg::OP_INSERT: begin
          if (!ins_ok) begin
            res_valid_d  = 1'b1;
            res_status_d = ils_pkg::ST_RANGE;
          end else if (full) begin
            res_valid_d  = 1'b1;
            res_status_d = ils_pkg::ST_FULL;
          end else begin
            state_d = S_RUN;
            slot_d  = pos_s[AW-1:0];
            issue_d = (CNT_W'(pos_s[AW-1:0]) != count_q);
            ptr_d   = cnt_m1;
            last_d  = pos_s[AW-1:0];
          end
        end
        ils_pkg::OP_REMOVE, ils_pkg::OP_GET: begin
          if (!rg_ok) begin
            res_valid_d  = 1'b1;
            res_status_d = ils_pkg::ST_RANGE;
          end else begin
            state_d = S_RUN;
            slot_d  = idx_s[AW-1:0];
            issue_d = 1'b1;
            ptr_d   = idx_s[AW-1:0];
            last_d  = (opcode_i == ils_pkg::OP_GET) ? idx_s[AW-1:0] : cnt_m1;
          end
        end
        ils_pkg::OP_CLEAR: begin
          res_valid_d = 1'b1;
          count_d     = '0;
        end
        default: begin
          res_valid_d = 1'b1;
        end
      endcase
    end else if (state_q == S_RUN) begin
      if (issue_q) begin
        if (ptr_q == last_q) begin
          issue_d = 1'b0;
        end else if (op_q == ils_pkg::OP_INSERT) begin
          ptr_d = ptr_q - AW'(1);
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      if (capture) begin
        res_word_d = rdata_q;
      end
      if (shift_wr) begin
        we    = 1'b1;
        waddr = (op_q == ils_pkg::OP_INSERT) ? (raddr_q + AW'(1)) : (raddr_q - AW'(1));
        wdata = rdata_q;
      end else if (finish && (op_q == ils_pkg::OP_INSERT)) begin
        we    = 1'b1;
        waddr = slot_q;
        wdata = word_q;
      end
      if (finish) begin
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
        if (op_q == ils_pkg::OP_INSERT) begin
          count_d = count_q + CNT_W'(1);
        end else if (op_q == ils_pkg::OP_REMOVE) begin
          count_d = count_q - CNT_W'(1);
        end
      end
    end
  end

  assign rv_d = re;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= 1'b0;
      rv_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      rv_q        <= rv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    slot_q       <= slot_d;
    ptr_q        <= ptr_d;
    last_q       <= last_d;
    word_q       <= word_d;
    res_word_q   <= res_word_d;
    res_status_q <= res_status_d;
  end

  // Element memory: one write and one registered read per cycle. Shifts move
  // away from the read pointer, so a read never meets a pending write.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[ptr_q];
      raddr_q <= ptr_q;
    end
  end

  assign res_wide       = RB'(res_word_q);
  assign cnt_wide       = HB'(count_q);
  assign result_valid_o = res_valid_q;
  assign read_value_o   = res_wide[ils_pkg::ValueBits-1:0];
  assign status_o       = res_status_q;
  assign held_count_o   = cnt_wide[ils_pkg::CountBits-1:0];

`ifndef SYNTHESIS
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (result_valid_o || busy))
    else $error("command transfer gave neither a result nor a sweep");

  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("sweep ended without a result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == ils_pkg::ST_DONE || status_o == ils_pkg::ST_RANGE ||
                        status_o == ils_pkg::ST_FULL))
    else $error("undefined status code");
`endif

endmodule
